[hw/rtl/gpg_pkg.sv]
// Shared types, constants and the 5x7 font table of the glyph pixel generator.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package gpg_pkg;

  localparam logic [7:0] CODE_LO     = 8'd32;
  localparam logic [7:0] CODE_HI     = 8'd90;
  localparam logic [7:0] CODE_SUBST  = 8'd63;
  localparam logic [7:0] LOWER_A     = 8'd97;
  localparam logic [7:0] LOWER_Z     = 8'd122;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam int unsigned FONT_COLS  = 5;
  localparam int unsigned FONT_ROWS  = 7;
  localparam int unsigned CELL_COLS  = 6;
  localparam int unsigned CELL_ROWS  = 8;
  localparam int unsigned LANES      = 4;

  localparam logic [1:0] REG_FG_COLOR    = 2'd0;
  localparam logic [1:0] REG_BG_COLOR    = 2'd1;
  localparam logic [1:0] REG_PIXEL_SCALE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [3:0] px;
    logic [3:0] py;
  } pos_t;

  typedef logic [15:0] pixel_t;

  function automatic logic [5:0] glyph_index(input logic [7:0] code);
    logic [7:0] folded;
    folded = code;
    if (code >= LOWER_A && code <= LOWER_Z) begin
      folded = code - CASE_OFFSET;
    end
    if (folded < CODE_LO || folded > CODE_HI) begin
      folded = CODE_SUBST;
    end
    return 6'(folded - CODE_LO);
  endfunction

  // Five column bytes, leftmost column in the top byte; bit r is row r.
  function automatic logic [39:0] font_glyph(input logic [5:0] idx);
    logic [39:0] g;
    unique case (idx)
      6'd0:  g = 40'h00_00_00_00_00;
      6'd1:  g = 40'h00_00_5F_00_00;
      6'd2:  g = 40'h00_07_00_07_00;
      6'd3:  g = 40'h14_7F_14_7F_14;
      6'd4:  g = 40'h24_2A_7F_2A_12;
      6'd5:  g = 40'h23_13_08_64_62;
      6'd6:  g = 40'h36_49_55_22_50;
      6'd7:  g = 40'h00_05_03_00_00;
      6'd8:  g = 40'h00_1C_22_41_00;
      6'd9:  g = 40'h00_41_22_1C_00;
      6'd10: g = 40'h14_08_3E_08_14;
      6'd11: g = 40'h08_08_3E_08_08;
      6'd12: g = 40'h00_50_30_00_00;
      6'd13: g = 40'h08_08_08_08_08;
      6'd14: g = 40'h00_60_60_00_00;
      6'd15: g = 40'h20_10_08_04_02;
      6'd16: g = 40'h3E_51_49_45_3E;
      6'd17: g = 40'h00_42_7F_40_00;
      6'd18: g = 40'h42_61_51_49_46;
      6'd19: g = 40'h21_41_45_4B_31;
      6'd20: g = 40'h18_14_12_7F_10;
      6'd21: g = 40'h27_45_45_45_39;
      6'd22: g = 40'h3C_4A_49_49_30;
      6'd23: g = 40'h01_71_09_05_03;
      6'd24: g = 40'h36_49_49_49_36;
      6'd25: g = 40'h06_49_49_29_1E;
      6'd26: g = 40'h00_36_36_00_00;
      6'd27: g = 40'h00_56_36_00_00;
      6'd28: g = 40'h08_14_22_41_00;
      6'd29: g = 40'h14_14_14_14_14;
      6'd30: g = 40'h00_41_22_14_08;
      6'd31: g = 40'h02_01_51_09_06;
      6'd32: g = 40'h32_49_79_41_3E;
      6'd33: g = 40'h7E_11_11_11_7E;
      6'd34: g = 40'h7F_49_49_49_36;
      6'd35: g = 40'h3E_41_41_41_22;
      6'd36: g = 40'h7F_41_41_22_1C;
      6'd37: g = 40'h7F_49_49_49_41;
      6'd38: g = 40'h7F_09_09_09_01;
      6'd39: g = 40'h3E_41_49_49_7A;
      6'd40: g = 40'h7F_08_08_08_7F;
      6'd41: g = 40'h00_41_7F_41_00;
      6'd42: g = 40'h20_40_41_3F_01;
      6'd43: g = 40'h7F_08_14_22_41;
      6'd44: g = 40'h7F_40_40_40_40;
      6'd45: g = 40'h7F_02_0C_02_7F;
      6'd46: g = 40'h7F_04_08_10_7F;
      6'd47: g = 40'h3E_41_41_41_3E;
      6'd48: g = 40'h7F_09_09_09_06;
      6'd49: g = 40'h3E_41_51_21_5E;
      6'd50: g = 40'h7F_09_19_29_46;
      6'd51: g = 40'h46_49_49_49_31;
      6'd52: g = 40'h01_01_7F_01_01;
      6'd53: g = 40'h3F_40_40_40_3F;
      6'd54: g = 40'h1F_20_40_20_1F;
      6'd55: g = 40'h3F_40_38_40_3F;
      6'd56: g = 40'h63_14_08_14_63;
      6'd57: g = 40'h07_08_70_08_07;
      6'd58: g = 40'h61_51_49_45_43;
      default: g = 40'h00_00_00_00_00;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/glyph_pixel_generator_top.sv]
// Top level of the glyph pixel generator: registers, sequencer and result registers.
// Depends on gpg_pkg and gpg_pixel_unit.
//
//   Port group        Direction  Handshake
//   start/char,x,y    in         taken when start is high and busy is low
//   cfg_*             in         written when cfg_write is high
//   result_valid/...  out        each result shown for one cycle, no back-pressure
//
// A cell runs from acceptance to its last result in order: the item is latched,
// then the bounds check and font read are done, then one result per cycle comes
// from the four-lane pixel unit, 12 results at scale 1 and 48 at scale 2.
// An off-screen cell or a bad scale gives a single error result instead.
// Synchronous reset restores the register defaults and returns to idle.
`default_nettype none

module glyph_pixel_generator_top #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  char_code,
  input  wire logic [9:0]  x_pos,
  input  wire logic [9:0]  y_pos,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             result_valid,
  output logic [15:0]      pixel_a,
  output logic [15:0]      pixel_b,
  output logic [15:0]      pixel_c,
  output logic [15:0]      pixel_d,
  output logic             last_beat,
  output logic             out_of_bounds
);
  import gpg_pkg::*;

  state_t      state;
  state_t      state_next;
  logic [15:0] fg_color;
  logic [15:0] bg_color;
  logic [1:0]  pixel_scale;
  logic [7:0]  code;
  logic [9:0]  cell_x;
  logic [9:0]  cell_y;
  logic [39:0] glyph;
  pos_t        pos;
  logic        double;
  logic [10:0] right_edge;
  logic [10:0] bottom_edge;
  logic        reject;
  pixel_t      unit_pixels [LANES];
  pos_t        unit_pos_next;
  logic        unit_last;

  assign double      = (pixel_scale == 2'd2);
  assign right_edge  = {1'b0, cell_x} + (double ? 11'(CELL_COLS * 2) : 11'(CELL_COLS));
  assign bottom_edge = {1'b0, cell_y} + (double ? 11'(CELL_ROWS * 2) : 11'(CELL_ROWS));
  assign reject      = (pixel_scale == 2'd0) || (pixel_scale == 2'd3) ||
                       (right_edge > 11'(SCREEN_WIDTH)) || (bottom_edge > 11'(SCREEN_HEIGHT));
  assign busy        = (state != ST_IDLE);

  gpg_pixel_unit u_pixel_unit (
    .glyph    (glyph),
    .pos      (pos),
    .double   (double),
    .fg_color (fg_color),
    .bg_color (bg_color),
    .pixels   (unit_pixels),
    .pos_next (unit_pos_next),
    .last     (unit_last)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = reject ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (unit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      fg_color     <= 16'hFFFF;
      bg_color     <= 16'h0000;
      pixel_scale  <= 2'd1;
    end else begin
      state        <= state_next;
      result_valid <= (state == ST_EMIT) || (state == ST_CHECK && reject);
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FG_COLOR:    fg_color    <= cfg_data;
          REG_BG_COLOR:    bg_color    <= cfg_data;
          REG_PIXEL_SCALE: pixel_scale <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      code   <= char_code;
      cell_x <= x_pos;
      cell_y <= y_pos;
    end
    if (state == ST_CHECK) begin
      glyph         <= font_glyph(glyph_index(code));
      pos           <= '0;
      pixel_a       <= 16'h0000;
      pixel_b       <= 16'h0000;
      pixel_c       <= 16'h0000;
      pixel_d       <= 16'h0000;
      last_beat     <= 1'b1;
      out_of_bounds <= 1'b1;
    end else if (state == ST_EMIT) begin
      pos           <= unit_pos_next;
      pixel_a       <= unit_pixels[0];
      pixel_b       <= unit_pixels[1];
      pixel_c       <= unit_pixels[2];
      pixel_d       <= unit_pixels[3];
      last_beat     <= unit_last;
      out_of_bounds <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gpg_pixel_unit.sv]
// Pixel unit: turns a cell position and a latched glyph into four pixels.
// Depends on gpg_pkg for the position type and cell constants.
`default_nettype none

module gpg_pixel_unit (
  input  wire logic [39:0]   glyph,
  input  wire gpg_pkg::pos_t pos,
  input  wire logic          double,
  input  wire logic [15:0]   fg_color,
  input  wire logic [15:0]   bg_color,
  output gpg_pkg::pixel_t    pixels [gpg_pkg::LANES],
  output gpg_pkg::pos_t      pos_next,
  output logic               last
);
  import gpg_pkg::*;

  pos_t       lane_pos [LANES+1];
  logic [3:0] cw_m1;
  logic [3:0] ch_m1;

  assign cw_m1 = double ? 4'(CELL_COLS * 2 - 1) : 4'(CELL_COLS - 1);
  assign ch_m1 = double ? 4'(CELL_ROWS * 2 - 1) : 4'(CELL_ROWS - 1);

  always_comb begin
    logic [2:0] fx;
    logic [2:0] fy;
    logic [7:0] col;
    lane_pos[0] = pos;
    for (int k = 0; k < LANES; k++) begin
      fx = double ? lane_pos[k].px[3:1] : lane_pos[k].px[2:0];
      fy = double ? lane_pos[k].py[3:1] : lane_pos[k].py[2:0];
      case (fx)
        3'd0:    col = glyph[39:32];
        3'd1:    col = glyph[31:24];
        3'd2:    col = glyph[23:16];
        3'd3:    col = glyph[15:8];
        3'd4:    col = glyph[7:0];
        default: col = 8'h00;
      endcase
      if (32'(fy) < FONT_ROWS && col[fy]) begin
        pixels[k] = fg_color;
      end else begin
        pixels[k] = bg_color;
      end
      if (lane_pos[k].px == cw_m1) begin
        lane_pos[k+1].px = 4'd0;
        lane_pos[k+1].py = lane_pos[k].py + 4'd1;
      end else begin
        lane_pos[k+1].px = lane_pos[k].px + 4'd1;
        lane_pos[k+1].py = lane_pos[k].py;
      end
    end
  end

  assign pos_next = lane_pos[LANES];
  assign last     = (lane_pos[LANES-1].px == cw_m1) && (lane_pos[LANES-1].py == ch_m1);

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for glyph_pixel_generator_top: a directed table, then random glyphs.
// Expected pixel beats come from a local font predictor; depends on gpg_pkg and the RTL top.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gpg_pkg::pixel_t;
  import gpg_pkg::REG_FG_COLOR;
  import gpg_pkg::REG_BG_COLOR;
  import gpg_pkg::REG_PIXEL_SCALE;

  localparam int unsigned SCREEN_W     = 320;
  localparam int unsigned SCREEN_H     = 240;
  localparam int unsigned GLYPH_W      = 5;
  localparam int unsigned GLYPH_H      = 7;
  localparam int unsigned CELL_W       = 6;
  localparam int unsigned CELL_H       = 8;
  localparam logic [1:0]  REG_SPARE    = 2'd3;
  localparam logic [7:0]  FIRST_CODE   = 8'd32;
  localparam logic [7:0]  LAST_CODE    = 8'd90;
  localparam logic [7:0]  QMARK_CODE   = 8'd63;
  localparam logic [7:0]  LOWER_FIRST  = 8'd97;
  localparam logic [7:0]  LOWER_LAST   = 8'd122;
  localparam logic [7:0]  CASE_SHIFT   = 8'd32;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned BLOCK_ITEMS  = 14;
  localparam int unsigned BLOCKS       = 6;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 30;

  typedef struct packed {
    pixel_t pa;
    pixel_t pb;
    pixel_t pc;
    pixel_t pd;
    logic   last;
    logic   oob;
  } glyph_beat_t;

  typedef enum logic {ROW_CFG, ROW_GLYPH} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [15:0] data;
    logic [7:0]  code;
    logic [9:0]  x;
    logic [9:0]  y;
    logic        reject;
  } plan_row_t;

  localparam glyph_beat_t REJECT_BEAT = '{16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 1'b1};

  // Codes 32..90; five column bytes with the leftmost column in the top byte, bit r is row r.
  localparam logic [39:0] GLYPHS [0:58] = '{
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
    40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
    40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
    40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
    40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
    40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
    40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
    40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43
  };

  localparam int unsigned PLAN_ROWS = 27;

  localparam plan_row_t DIRECTED_PLAN [0:PLAN_ROWS-1] = '{
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h41, 10'd0,    10'd0,    1'b0},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h00, 10'd314,  10'd232,  1'b0},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'hFF, 10'd315,  10'd0,    1'b1},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h7A, 10'd0,    10'd233,  1'b1},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h61, 10'd100,  10'd100,  1'b0},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h7B, 10'd7,    10'd9,    1'b0},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h60, 10'd50,   10'd60,   1'b0},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h20, 10'd1,    10'd2,    1'b0},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h5A, 10'd200,  10'd31,   1'b0},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h5B, 10'd16,   10'd17,   1'b0},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h1F, 10'd40,   10'd41,   1'b0},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h7A, 10'd1023, 10'd1023, 1'b1},
    '{ROW_CFG,   REG_FG_COLOR,    16'h0000, 8'h00, 10'd0, 10'd0, 1'b0},
    '{ROW_CFG,   REG_BG_COLOR,    16'hFFFF, 8'h00, 10'd0, 10'd0, 1'b0},
    '{ROW_CFG,   REG_SPARE,       16'h1234, 8'h00, 10'd0, 10'd0, 1'b0},
    '{ROW_CFG,   REG_PIXEL_SCALE, 16'h0002, 8'h00, 10'd0, 10'd0, 1'b0},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h40, 10'd308,  10'd224,  1'b0},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h4D, 10'd309,  10'd0,    1'b1},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h4D, 10'd0,    10'd225,  1'b1},
    '{ROW_CFG,   REG_PIXEL_SCALE, 16'h0000, 8'h00, 10'd0, 10'd0, 1'b0},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h41, 10'd0,    10'd0,    1'b1},
    '{ROW_CFG,   REG_PIXEL_SCALE, 16'hFFFF, 8'h00, 10'd0, 10'd0, 1'b0},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h41, 10'd0,    10'd0,    1'b1},
    '{ROW_CFG,   REG_PIXEL_SCALE, 16'hFFFD, 8'h00, 10'd0, 10'd0, 1'b0},
    '{ROW_CFG,   REG_FG_COLOR,    16'hA5A5, 8'h00, 10'd0, 10'd0, 1'b0},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h23, 10'd1,    10'd1,    1'b0},
    '{ROW_GLYPH, REG_FG_COLOR, 16'h0000, 8'h38, 10'd200,  10'd100,  1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  char_code = 8'h00;
  logic [9:0]  x_pos = 10'd0;
  logic [9:0]  y_pos = 10'd0;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'h0000;
  logic        result_valid;
  logic [15:0] pixel_a;
  logic [15:0] pixel_b;
  logic [15:0] pixel_c;
  logic [15:0] pixel_d;
  logic        last_beat;
  logic        out_of_bounds;

  pixel_t      fg_shadow = 16'hFFFF;
  pixel_t      bg_shadow = 16'h0000;
  logic [1:0]  scale_shadow = 2'd1;
  glyph_beat_t beats_due [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  glyph_pixel_generator_top #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .char_code    (char_code),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .pixel_a      (pixel_a),
    .pixel_b      (pixel_b),
    .pixel_c      (pixel_c),
    .pixel_d      (pixel_d),
    .last_beat    (last_beat),
    .out_of_bounds(out_of_bounds)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void predict_glyph(input logic [7:0] code, input logic [9:0] x,
                                        input logic [9:0] y);
    int unsigned mag;
    int unsigned cw;
    int unsigned ch;
    int unsigned total;
    int unsigned fx;
    int unsigned fy;
    logic [7:0]  folded;
    logic [39:0] glyph;
    pixel_t      lanes [4];
    pixel_t      pix;
    mag = scale_shadow;
    cw = CELL_W * mag;
    ch = CELL_H * mag;
    if (mag == 0 || mag > 2 || x + cw > SCREEN_W || y + ch > SCREEN_H) begin
      beats_due.push_back(REJECT_BEAT);
      return;
    end
    folded = code;
    if (code >= LOWER_FIRST && code <= LOWER_LAST) begin
      folded = code - CASE_SHIFT;
    end
    if (folded < FIRST_CODE || folded > LAST_CODE) begin
      folded = QMARK_CODE;
    end
    glyph = GLYPHS[folded - FIRST_CODE];
    total = cw * ch;
    for (int unsigned p = 0; p < total; p++) begin
      fx = (p % cw) / mag;
      fy = (p / cw) / mag;
      pix = bg_shadow;
      if (fx < GLYPH_W && fy < GLYPH_H && glyph[8 * (4 - fx) + fy]) begin
        pix = fg_shadow;
      end
      lanes[p % 4] = pix;
      if (p % 4 == 3) begin
        beats_due.push_back('{lanes[0], lanes[1], lanes[2], lanes[3], p == total - 1, 1'b0});
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      if (fail_count < MAX_REPORTS) begin
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    glyph_beat_t want;
    if (!rst && result_valid) begin
      if (beats_due.size() == 0) begin
        if (fail_count < MAX_REPORTS) begin
          $display("%0t ns: unexpected result, expected none, actual %h %h %h %h last %b oob %b",
                   $time, pixel_a, pixel_b, pixel_c, pixel_d, last_beat, out_of_bounds);
        end
        fail_count++;
      end else begin
        want = beats_due.pop_front();
        check_field("pixel_a", want.pa, pixel_a);
        check_field("pixel_b", want.pb, pixel_b);
        check_field("pixel_c", want.pc, pixel_c);
        check_field("pixel_d", want.pd, pixel_d);
        check_field("last_beat", 16'(want.last), 16'(last_beat));
        check_field("out_of_bounds", 16'(want.oob), 16'(out_of_bounds));
      end
    end
  end

  task automatic send_glyph(input logic [7:0] code, input logic [9:0] x, input logic [9:0] y,
                            input logic reject);
    start <= 1'b1;
    char_code <= code;
    x_pos <= x;
    y_pos <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (reject) begin
      beats_due.push_back(REJECT_BEAT);
    end else begin
      predict_glyph(code, x, y);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_FG_COLOR: begin
        fg_shadow = val;
      end
      REG_BG_COLOR: begin
        bg_shadow = val;
      end
      REG_PIXEL_SCALE: begin
        scale_shadow = val[1:0];
      end
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic random_setup();
    logic [15:0] raw;
    int unsigned pick;
    raw = 16'($urandom);
    pick = $urandom_range(0, 11);
    if (pick == 0) begin
      raw[1:0] = 2'd0;
    end else if (pick == 1) begin
      raw[1:0] = 2'd3;
    end else begin
      raw[1:0] = (pick % 2 == 0) ? 2'd1 : 2'd2;
    end
    write_reg(REG_FG_COLOR, 16'($urandom));
    write_reg(REG_BG_COLOR, 16'($urandom));
    write_reg(REG_PIXEL_SCALE, raw);
    if ($urandom_range(0, 5) == 0) begin
      write_reg(REG_SPARE, 16'($urandom));
    end
  endtask

  task automatic random_glyph();
    logic [7:0]  code;
    logic [9:0]  x;
    logic [9:0]  y;
    int unsigned mag;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      code = 8'($urandom_range(FIRST_CODE, LAST_CODE));
    end else if (pick < 70) begin
      code = 8'($urandom_range(LOWER_FIRST, LOWER_LAST));
    end else begin
      code = 8'($urandom_range(0, 255));
    end
    mag = (scale_shadow == 2'd2) ? 2 : 1;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      x = 10'($urandom_range(0, SCREEN_W - CELL_W * mag));
      y = 10'($urandom_range(0, SCREEN_H - CELL_H * mag));
    end else if (pick < 90) begin
      x = 10'(SCREEN_W - CELL_W * mag + $urandom_range(0, 1));
      y = 10'(SCREEN_H - CELL_H * mag + $urandom_range(0, 1));
    end else begin
      x = 10'($urandom_range(0, 1023));
      y = 10'($urandom_range(0, 1023));
    end
    send_glyph(code, x, y, 1'b0);
  endtask

  initial begin
    int unsigned idle_pct;
    plan_row_t   row;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int unsigned r = 0; r < PLAN_ROWS; r++) begin
      row = DIRECTED_PLAN[r];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        send_glyph(row.code, row.x, row.y, row.reject);
      end
    end

    for (int unsigned phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 21 : (phase == 1) ? 45 : 0;
      for (int unsigned b = 0; b < BLOCKS; b++) begin
        settle();
        random_setup();
        for (int unsigned i = 0; i < BLOCK_ITEMS; i++) begin
          random_glyph();
          if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clk);
          end
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
